FILE: sv/hsal_pkg.sv
// Hall steering angle linearizer: shared types, widths, offsets and coefficient tables.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package hsal_pkg;

  localparam int VOLT_W   = 16;
  localparam int ANG_W    = 16;
  localparam int APB_W    = 32;
  localparam int ADDR_W   = 4;
  localparam int NLANE    = 2;
  localparam int NSET     = 4;

  localparam int FRAC     = 13;
  localparam int RND      = 1 << (FRAC - 1);
  localparam int U_W      = 18;
  localparam int SQ_W     = 2 * U_W - 1;
  localparam int S_W      = SQ_W + 1 - FRAC;

  localparam int COEF_W   = 25;
  localparam int NCOEF    = 6;
  localparam int NSTEP    = NCOEF - 1;
  localparam int ACC_W    = 46;
  localparam int LO_W     = 24;
  localparam int HI_W     = ACC_W - LO_W;
  localparam int PLO_W    = LO_W + S_W;
  localparam int PHI_W    = HI_W + S_W + 1;
  localparam int SUM_W    = ACC_W + S_W + 1;

  // accumulator Q24 -> angle Q13, one extra bit so a single estimate doubles into the sum
  localparam int X_W      = ACC_W + 1;
  localparam int OUT_SH   = 24 - FRAC + 1;
  localparam int OUT_RND  = 1 << (OUT_SH - 1);
  localparam int R_W      = X_W - OUT_SH;

  localparam int EST_LAT  = 2 + 2 * NSTEP;
  localparam int OUT_LAT  = EST_LAT + 3;

  localparam logic signed [ANG_W-1:0] ANG_MAX = 16'sh7fff;
  localparam logic signed [ANG_W-1:0] ANG_MIN = 16'sh8000;

  localparam logic [VOLT_W-1:0] FRONT_FIRST_THR_RST  = 16'd15565;
  localparam logic [VOLT_W-1:0] FRONT_SECOND_THR_RST = 16'd15565;
  localparam logic [VOLT_W-1:0] REAR_FIRST_THR_RST   = 16'd14746;
  localparam logic [VOLT_W-1:0] REAR_SECOND_THR_RST  = 16'd15565;

  typedef enum logic [1:0] {
    SRC_FIRST  = 2'd0,
    SRC_SECOND = 2'd1,
    SRC_AVG    = 2'd2
  } src_t;

  typedef enum logic [1:0] {
    REG_FRONT_FIRST  = 2'd0,
    REG_FRONT_SECOND = 2'd1,
    REG_REAR_FIRST   = 2'd2,
    REG_REAR_SECOND  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic vld;
    src_t src;
  } tag_t;

  // set index = {axle, sensor}
  localparam logic signed [U_W-1:0] OFFSET [NSET] = '{
    18'sd8409, 18'sd8328, 18'sd6226, -18'sd3131
  };

  // Q24 coefficients, c0 first, padded with leading zeros to a common degree
  localparam logic signed [COEF_W-1:0] COEF [NSET][NCOEF] = '{
    '{ 25'sd7148419, -25'sd3769874, -25'sd2296918, 25'sd0, 25'sd0, 25'sd0},
    '{-25'sd6783230,  25'sd8941786, -25'sd4707251, 25'sd2494436, 25'sd0, 25'sd0},
    '{-25'sd6086086,  25'sd5232143, -25'sd1989476, 25'sd684057, 25'sd61639, 25'sd0},
    '{ 25'sd6914998, -25'sd2120120,  25'sd1074262, -25'sd392738, 25'sd61488,
      -25'sd3624}
  };

endpackage

`default_nettype wire

FILE: sv/hsal_est.sv
// Two-lane estimate pipeline: offset, square, then Horner steps split into
// partial-product and accumulate stages. Depends on hsal_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsal_est
  import hsal_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  tag_t                         tag_in,
  input  logic                         axle,
  input  logic [NLANE-1:0][VOLT_W-1:0] volts,
  output tag_t                         tag_out,
  output logic [NLANE-1:0][ACC_W-1:0]  est
);

  tag_t tag1;
  logic axle1;
  logic [SQ_W-1:0] sq [NLANE];

  tag_t tag_b [0:NSTEP];
  logic axle_b [0:NSTEP-1];
  logic [S_W-1:0] s_b [0:NSTEP-1][NLANE];
  logic signed [ACC_W-1:0] acc_b [0:NSTEP][NLANE];

  tag_t tag_a [0:NSTEP-1];
  logic axle_a [0:NSTEP-1];
  logic [S_W-1:0] s_a [0:NSTEP-1][NLANE];
  logic [PLO_W-1:0] plo [0:NSTEP-1][NLANE];
  logic signed [PHI_W-1:0] phi [0:NSTEP-1][NLANE];
  logic neg [0:NSTEP-1][NLANE];

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1.vld   <= 1'b0;
      tag_b[0].vld <= 1'b0;
    end else begin
      tag1     <= tag_in;
      tag_b[0] <= tag1;
    end
    axle1     <= axle;
    axle_b[0] <= axle1;
  end

  for (genvar l = 0; l < NLANE; l++) begin : g_front
    logic signed [U_W-1:0] u;
    logic signed [2*U_W-1:0] uu;
    logic [SQ_W:0] sq_rnd;

    always_comb begin
      u      = signed'({{(U_W-VOLT_W){1'b0}}, volts[l]}) - OFFSET[{axle, 1'(l)}];
      uu     = u * u;
      sq_rnd = {1'b0, sq[l]} + (SQ_W+1)'(RND);
    end

    always_ff @(posedge clk) begin
      sq[l]       <= uu[SQ_W-1:0];
      s_b[0][l]   <= sq_rnd[SQ_W:FRAC];
      acc_b[0][l] <= ACC_W'(COEF[{axle1, 1'(l)}][NCOEF-1]);
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        tag_a[k].vld   <= 1'b0;
        tag_b[k+1].vld <= 1'b0;
      end else begin
        tag_a[k]   <= tag_b[k];
        tag_b[k+1] <= tag_a[k];
      end
      axle_a[k] <= axle_b[k];
    end

    if (k < NSTEP - 1) begin : g_fwd
      always_ff @(posedge clk) begin
        axle_b[k+1] <= axle_a[k];
      end
    end

    for (genvar l = 0; l < NLANE; l++) begin : g_lane
      logic signed [HI_W-1:0] hi;
      logic signed [S_W:0] sx;
      logic signed [COEF_W-1:0] c;
      logic [SUM_W-1:0] sum;

      always_comb begin
        hi  = acc_b[k][l][ACC_W-1:LO_W];
        sx  = {1'b0, s_b[k][l]};
        c   = COEF[{axle_a[k], 1'(l)}][NCOEF-2-k];
        // floor((acc*s + half - neg) / 2^13) + c, with c folded in above the fraction
        sum = {phi[k][l], {LO_W{1'b0}}}
            + {{(SUM_W-PLO_W){1'b0}}, plo[k][l]}
            + SUM_W'(RND)
            - {{(SUM_W-1){1'b0}}, neg[k][l]}
            + {{(SUM_W-COEF_W-FRAC){c[COEF_W-1]}}, c, {FRAC{1'b0}}};
      end

      always_ff @(posedge clk) begin
        plo[k][l]     <= acc_b[k][l][LO_W-1:0] * s_b[k][l];
        phi[k][l]     <= hi * sx;
        neg[k][l]     <= acc_b[k][l][ACC_W-1] & (|s_b[k][l]);
        s_a[k][l]     <= s_b[k][l];
        acc_b[k+1][l] <= sum[FRAC +: ACC_W];
      end

      if (k < NSTEP - 1) begin : g_sfwd
        always_ff @(posedge clk) begin
          s_b[k+1][l] <= s_a[k][l];
        end
      end
    end
  end

  assign tag_out = tag_b[NSTEP];

  for (genvar l = 0; l < NLANE; l++) begin : g_out
    assign est[l] = acc_b[NSTEP][l];
  end

endmodule

`default_nettype wire

FILE: sv/hall_steer_angle_linearizer_top.sv
// Hall steering angle linearizer top: APB thresholds, request capture, estimate
// pipeline, source select, rounding and saturation. Depends on hsal_pkg, hsal_est.
`timescale 1ns / 1ps
`default_nettype none

// One request (axle, first_volts, second_volts) is taken on every clock where
// start is high and busy is low; busy is high only while rst is held. The block is a
// fixed 15-stage pipeline: the result appears with done from the last of these stages,
// one result per cycle at full rate, in request order. There is no output
// backpressure, so done, steer_angle and angle_source must be captured in the cycle
// they are shown. The pipeline length is set by the five Horner steps of the
// polynomial, each a partial-product stage and an accumulate stage. Thresholds are
// sampled when the request is taken; write them over APB only while no request is
// in flight.
module hall_steer_angle_linearizer_top
  import hsal_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic                     axle,
  input  logic [VOLT_W-1:0]        first_volts,
  input  logic [VOLT_W-1:0]        second_volts,
  output logic                     done,
  output logic signed [ANG_W-1:0]  steer_angle,
  output logic [1:0]               angle_source,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [APB_W-1:0]         pwdata,
  output logic [APB_W-1:0]         prdata,
  output logic                     pready
);

  logic [VOLT_W-1:0] front_first_thr;
  logic [VOLT_W-1:0] front_second_thr;
  logic [VOLT_W-1:0] rear_first_thr;
  logic [VOLT_W-1:0] rear_second_thr;
  reg_idx_t          reg_idx;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      front_first_thr  <= FRONT_FIRST_THR_RST;
      front_second_thr <= FRONT_SECOND_THR_RST;
      rear_first_thr   <= REAR_FIRST_THR_RST;
      rear_second_thr  <= REAR_SECOND_THR_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FRONT_FIRST:  front_first_thr  <= pwdata[VOLT_W-1:0];
        REG_FRONT_SECOND: front_second_thr <= pwdata[VOLT_W-1:0];
        REG_REAR_FIRST:   rear_first_thr   <= pwdata[VOLT_W-1:0];
        REG_REAR_SECOND:  rear_second_thr  <= pwdata[VOLT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRONT_FIRST:  prdata = {{(APB_W-VOLT_W){1'b0}}, front_first_thr};
      REG_FRONT_SECOND: prdata = {{(APB_W-VOLT_W){1'b0}}, front_second_thr};
      REG_REAR_FIRST:   prdata = {{(APB_W-VOLT_W){1'b0}}, rear_first_thr};
      REG_REAR_SECOND:  prdata = {{(APB_W-VOLT_W){1'b0}}, rear_second_thr};
      default:          prdata = '0;
    endcase
  end

  // request capture and source decision
  logic                         accept;
  logic [VOLT_W-1:0]            th1;
  logic [VOLT_W-1:0]            th2;
  src_t                         src_in;
  tag_t                         tag0;
  logic                         axle0;
  logic [NLANE-1:0][VOLT_W-1:0] volts0;

  assign busy   = rst;
  assign accept = start && !busy;

  always_comb begin
    th1 = axle ? rear_first_thr : front_first_thr;
    th2 = axle ? rear_second_thr : front_second_thr;
    if (first_volts < th1) begin
      src_in = SRC_FIRST;
    end else if (second_volts < th2) begin
      src_in = SRC_SECOND;
    end else begin
      src_in = SRC_AVG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag0.vld <= 1'b0;
    end else begin
      tag0.vld <= accept;
    end
    if (accept) begin
      tag0.src  <= src_in;
      axle0     <= axle;
      volts0[0] <= first_volts;
      volts0[1] <= second_volts;
    end
  end

  tag_t                        tag_e;
  logic [NLANE-1:0][ACC_W-1:0] est;

  hsal_est u_est (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (tag0),
    .axle    (axle0),
    .volts   (volts0),
    .tag_out (tag_e),
    .est     (est)
  );

  // select: single estimates are doubled so every case rounds by the same shift
  logic signed [ACC_W-1:0] a1;
  logic signed [ACC_W-1:0] a2;
  logic signed [X_W-1:0]   x_next;
  logic signed [X_W-1:0]   x;
  tag_t                    tag_f;

  always_comb begin
    a1 = signed'(est[0]);
    a2 = signed'(est[1]);
    case (tag_e.src)
      SRC_FIRST:  x_next = {a1, 1'b0};
      SRC_SECOND: x_next = {a2, 1'b0};
      default:    x_next = {a1[ACC_W-1], a1} + {a2[ACC_W-1], a2};
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_f.vld <= 1'b0;
    end else begin
      tag_f <= tag_e;
    end
    x <= x_next;
  end

  // round half away from zero, then saturate
  logic [X_W-1:0]             t;
  logic [R_W-1:0]             r;
  logic signed [ANG_W-1:0]    angle_next;

  always_comb begin
    t = x + X_W'(OUT_RND - 1) + {{(X_W-1){1'b0}}, !x[X_W-1]};
    r = t[X_W-1:OUT_SH];
    if ((&r[R_W-1:ANG_W-1]) || !(|r[R_W-1:ANG_W-1])) begin
      angle_next = signed'(r[ANG_W-1:0]);
    end else if (r[R_W-1]) begin
      angle_next = ANG_MIN;
    end else begin
      angle_next = ANG_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tag_f.vld;
    end
    steer_angle  <= angle_next;
    angle_source <= tag_f.src;
  end

endmodule

`default_nettype wire

FILE: sv/hsal_checker.sv
// Port-level checks for the Hall steering angle linearizer and their bind.
// Depends on hsal_pkg and hall_steer_angle_linearizer_top.
`timescale 1ns / 1ps
`default_nettype none

module hsal_checker
  import hsal_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input logic [1:0]        angle_source,
  input logic [APB_W-1:0]  prdata,
  input logic              pready
);

  a_req_to_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##OUT_LAT done)
    else $error("request without result at fixed latency");

  a_result_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, OUT_LAT))
    else $error("result without matching request");

  a_source_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (angle_source == SRC_FIRST || angle_source == SRC_SECOND ||
              angle_source == SRC_AVG))
    else $error("undefined angle source");

  a_cfg_read: assert property (@(posedge clk) disable iff (rst)
    pready && (prdata[APB_W-1:VOLT_W] == '0))
    else $error("config read out of range or not ready");

endmodule

bind hall_steer_angle_linearizer_top hsal_checker u_hsal_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .angle_source (angle_source),
  .prdata       (prdata),
  .pready       (pready)
);

`default_nettype wire
